// ===== rtl/kvrp_pkg.sv =====
// Package for the key-value record parser: phase codes, byte class codes,
// the parser state and result structures. No dependencies.
`default_nettype none

package kvrp_pkg;

	// Parser phase, one-hot coded.
	typedef enum logic [4:0] {
		PH_KEY_HDR = 5'b00001,
		PH_KEY     = 5'b00010,
		PH_VAL_HDR = 5'b00100,
		PH_LEN     = 5'b01000,
		PH_VAL     = 5'b10000
	} phase_t;

	typedef logic [2:0] byte_class_t;

	localparam byte_class_t CL_KEY_HDR = 3'd0;
	localparam byte_class_t CL_KEY     = 3'd1;
	localparam byte_class_t CL_VAL_HDR = 3'd2;
	localparam byte_class_t CL_LEN     = 3'd3;
	localparam byte_class_t CL_VAL     = 3'd4;
	localparam byte_class_t CL_ERROR   = 3'd5;

	// Longest big-endian length field of the long value form.
	localparam logic [6:0] MaxLenBytes = 7'd4;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] remaining;
		logic        has_value;
		logic [2:0]  length_bytes_left;
		logic [31:0] length_accum;
	} state_t;

	typedef struct packed {
		byte_class_t byte_class;
		logic [7:0]  data;
		logic [31:0] value_length;
		logic        key_last;
		logic        record_end;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/kvrp_if.sv =====
// Valid/ready channel interfaces for the key-value record parser.
// Depends on kvrp_pkg for the byte class type.
`default_nettype none

interface kvrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface kvrp_out_if;
	logic                 valid;
	logic                 ready;
	kvrp_pkg::byte_class_t byte_class;
	logic [7:0]           data;
	logic [31:0]          value_length;
	logic                 key_last;
	logic                 record_end;

	modport source (output valid, output byte_class, output data, output value_length,
		output key_last, output record_end, input ready);
	modport sink (input valid, input byte_class, input data, input value_length,
		input key_last, input record_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/key_value_record_parser.sv =====
// Key-value record parser: labels each byte of the record stream with its role.
// A result is registered and presented in the cycle after the transfer of its byte.
// Throughput: one byte per cycle while the output is taken; the result register frees
// in the same cycle it is taken, so a stall on the output side only holds the input back.
// Reset: arst_n clears the phase to awaiting a key header, all counters to zero
// and the result register to empty. Depends on kvrp_pkg, kvrp_if, kvrp_step.
`default_nettype none

module key_value_record_parser (
	input  var logic         clk,
	input  var logic         arst_n,
	kvrp_in_if.sink          rx,
	kvrp_out_if.source       tx
);

	kvrp_pkg::state_t  state_q;
	kvrp_pkg::state_t  state_nxt;
	kvrp_pkg::result_t res_nxt;
	kvrp_pkg::result_t res_q;
	logic              out_vld_q;
	logic              rx_fire;

	kvrp_step u_step (
		.cur     (state_q),
		.in_byte (rx.in_byte),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	assign rx.ready = !out_vld_q || tx.ready;
	assign rx_fire  = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase             <= kvrp_pkg::PH_KEY_HDR;
			state_q.remaining         <= '0;
			state_q.has_value         <= 1'b0;
			state_q.length_bytes_left <= '0;
			state_q.length_accum      <= '0;
			out_vld_q                 <= 1'b0;
		end else begin
			if (rx_fire) begin
				state_q <= state_nxt;
			end
			if (rx_fire) begin
				out_vld_q <= 1'b1;
			end else if (tx.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			res_q <= res_nxt;
		end
	end

	assign tx.valid        = out_vld_q;
	assign tx.byte_class   = res_q.byte_class;
	assign tx.data         = res_q.data;
	assign tx.value_length = res_q.value_length;
	assign tx.key_last     = res_q.key_last;
	assign tx.record_end   = res_q.record_end;

	// A transfer always leaves a result waiting in the next cycle.
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire |=> out_vld_q)
		else $error("accepted byte produced no result");

	// Ending a record or flagging an error returns the parser to the key header.
	a_end_to_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && (res_nxt.record_end || res_nxt.byte_class == kvrp_pkg::CL_ERROR)
		|=> state_q.phase == kvrp_pkg::PH_KEY_HDR)
		else $error("parser did not return to key header");

	// key_last appears only on key bytes.
	a_key_last_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.key_last |-> res_q.byte_class == kvrp_pkg::CL_KEY)
		else $error("key_last on a non-key byte");

	// An error result carries no length and ends nothing.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.byte_class == kvrp_pkg::CL_ERROR
		|-> res_q.value_length == '0 && !res_q.record_end && !res_q.key_last)
		else $error("error result with stray fields");

	// A length phase never starts with an empty count.
	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == kvrp_pkg::PH_LEN |-> state_q.length_bytes_left != '0)
		else $error("length phase with no length bytes left");

endmodule

`default_nettype wire

// ===== rtl/kvrp_step.sv =====
// Next-state and result logic for one byte of the record stream.
// Purely combinational; depends on kvrp_pkg.
`default_nettype none

module kvrp_step (
	input  var kvrp_pkg::state_t  cur,
	input  var logic [7:0]        in_byte,
	output var kvrp_pkg::state_t  nxt,
	output var kvrp_pkg::result_t res
);

	logic [31:0] rem_dec;
	logic [31:0] accum_shift;
	logic [2:0]  left_dec;
	logic [6:0]  len_cnt;

	assign rem_dec     = cur.remaining - 32'd1;
	assign accum_shift = {cur.length_accum[23:0], in_byte};
	assign left_dec    = cur.length_bytes_left - 3'd1;
	assign len_cnt     = {1'b0, in_byte[5:0]} + 7'd1;

	always_comb begin
		nxt = cur;
		res.byte_class   = kvrp_pkg::CL_KEY_HDR;
		res.data         = in_byte;
		res.value_length = '0;
		res.key_last     = 1'b0;
		res.record_end   = 1'b0;

		unique case (cur.phase)
			kvrp_pkg::PH_KEY: begin
				res.byte_class = kvrp_pkg::CL_KEY;
				nxt.remaining  = rem_dec;
				if (rem_dec == '0) begin
					res.key_last = 1'b1;
					if (cur.has_value) begin
						nxt.phase = kvrp_pkg::PH_VAL_HDR;
					end else begin
						res.record_end = 1'b1;
						nxt.phase      = kvrp_pkg::PH_KEY_HDR;
					end
				end
			end
			kvrp_pkg::PH_VAL_HDR: begin
				priority if (!in_byte[7]) begin
					// Immediate value carried in the header itself.
					res.byte_class   = kvrp_pkg::CL_VAL_HDR;
					res.data         = {1'b0, in_byte[6:0]};
					res.value_length = 32'd1;
					res.record_end   = 1'b1;
					nxt.length_accum = 32'd1;
					nxt.phase        = kvrp_pkg::PH_KEY_HDR;
				end else if (!in_byte[6]) begin
					res.byte_class   = kvrp_pkg::CL_VAL_HDR;
					res.value_length = {25'd0, len_cnt};
					nxt.length_accum = {25'd0, len_cnt};
					nxt.remaining    = {25'd0, len_cnt};
					nxt.phase        = kvrp_pkg::PH_VAL;
				end else if (len_cnt > kvrp_pkg::MaxLenBytes) begin
					res.byte_class = kvrp_pkg::CL_ERROR;
					nxt.phase      = kvrp_pkg::PH_KEY_HDR;
				end else begin
					res.byte_class        = kvrp_pkg::CL_VAL_HDR;
					nxt.length_bytes_left = len_cnt[2:0];
					nxt.length_accum      = '0;
					nxt.phase             = kvrp_pkg::PH_LEN;
				end
			end
			kvrp_pkg::PH_LEN: begin
				res.byte_class        = kvrp_pkg::CL_LEN;
				nxt.length_accum      = accum_shift;
				nxt.length_bytes_left = left_dec;
				if (left_dec == '0) begin
					res.value_length = accum_shift;
					if (accum_shift == '0) begin
						// A zero length closes the record on its last length byte.
						res.record_end = 1'b1;
						nxt.phase      = kvrp_pkg::PH_KEY_HDR;
					end else begin
						nxt.remaining = accum_shift;
						nxt.phase     = kvrp_pkg::PH_VAL;
					end
				end
			end
			kvrp_pkg::PH_VAL: begin
				res.byte_class   = kvrp_pkg::CL_VAL;
				res.value_length = cur.length_accum;
				nxt.remaining    = rem_dec;
				if (rem_dec == '0) begin
					res.record_end = 1'b1;
					nxt.phase      = kvrp_pkg::PH_KEY_HDR;
				end
			end
			default: begin
				res.byte_class        = kvrp_pkg::CL_KEY_HDR;
				nxt.has_value         = in_byte[7];
				nxt.remaining         = {24'd0, 1'b0, in_byte[6:0]} + 32'd1;
				nxt.length_accum      = '0;
				nxt.length_bytes_left = '0;
				nxt.phase             = kvrp_pkg::PH_KEY;
			end
		endcase
	end

endmodule

`default_nettype wire
